[rtl/btf_pkg.sv]
// ----------------------------------------------------------------------------
// btf_pkg
// Shared types and constants of the bus telegram framer.
// ----------------------------------------------------------------------------
package btf_pkg;

  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OUT_DEPTH  = 2;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HIGH     = 2'd2;

  localparam logic [7:0] OWN_ADDR_HIGH_RST = 8'h11;
  localparam logic [7:0] OWN_ADDR_LOW_RST  = 8'h02;
  localparam logic [7:0] DEST_HIGH_RST     = 8'h11;

  localparam logic [7:0] CTRL_BASE        = 8'h90;
  localparam logic [7:0] CTRL_REPEAT_MASK = 8'hDF;
  localparam logic [7:0] CTRL_NOREPEAT    = 8'h20;

  typedef struct packed {
    logic [7:0] own_addr_high;
    logic [7:0] own_addr_low;
    logic [7:0] dest_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr;
    logic [7:0] ctrl;
    logic [7:0] dest_low;
    logic [3:0] length;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } res_t;

  typedef enum logic [7:0] {
    ST_CTRL  = 8'b0000_0001,
    ST_SRC_H = 8'b0000_0010,
    ST_SRC_L = 8'b0000_0100,
    ST_DST_H = 8'b0000_1000,
    ST_DST_L = 8'b0001_0000,
    ST_LEN   = 8'b0010_0000,
    ST_DATA  = 8'b0100_0000,
    ST_CHK   = 8'b1000_0000
  } step_e;

endpackage

[rtl/btf_front.sv]
// ----------------------------------------------------------------------------
// btf_front
// Accepts payload bytes, marks frame starts, builds the control byte and
// queues one command per request for the back end.
// ----------------------------------------------------------------------------
module btf_front import btf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic [1:0] priority_req_i,
  input  logic       repeat_flag_i,
  input  logic [7:0] dest_low_i,
  input  logic [3:0] length_code_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 frame_open_q, frame_open_d;
  logic                 wr_en;
  logic                 rd_en;
  logic [7:0]           ctrl;
  cmd_t                 cmd_new;

  assign full        = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    if (repeat_flag_i) begin
      ctrl = CTRL_BASE & CTRL_REPEAT_MASK;
    end else begin
      ctrl = CTRL_BASE | CTRL_NOREPEAT;
    end
    ctrl = ctrl | {4'b0000, priority_req_i, 2'b00};
    cmd_new.data     = data_byte_i;
    cmd_new.last     = last_byte_i;
    cmd_new.hdr      = !frame_open_q;
    cmd_new.ctrl     = ctrl;
    cmd_new.dest_low = dest_low_i;
    cmd_new.length   = length_code_i;
  end

  always_comb begin
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    cnt_d        = cnt_q;
    frame_open_d = frame_open_q;
    if (wr_en) begin
      wr_ptr_d     = wr_ptr_q + 1'b1;
      frame_open_d = !last_byte_i;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
      frame_open_q <= 1'b0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      cnt_q        <= cnt_d;
      frame_open_q <= frame_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[rtl/btf_back.sv]
// ----------------------------------------------------------------------------
// btf_back
// Steps through each command one byte a cycle unless the result queue is full,
// keeps the running checksum and holds finished bytes in a small result queue.
// ----------------------------------------------------------------------------
module btf_back import btf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  step_e                step_q, step_d;
  step_e                step_cur;
  logic                 mid_q, mid_d;
  logic [7:0]           accum_q, accum_d;
  res_t                 res_new;
  logic                 emit;
  logic                 cmd_done;

  res_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 out_full;
  logic                 rd_en;

  assign out_full = (cnt_q == OUT_CNT_W'(OUT_DEPTH));
  assign empty    = (cnt_q == '0);
  assign res_o    = mem_q[rd_ptr_q];
  assign rd_en    = pop && !empty;
  assign emit     = cmd_valid_i && !out_full;

  always_comb begin
    if (mid_q) begin
      step_cur = step_q;
    end else if (cmd_i.hdr) begin
      step_cur = ST_CTRL;
    end else begin
      step_cur = ST_DATA;
    end
  end

  always_comb begin
    res_new.run_last  = 1'b0;
    res_new.frame_end = 1'b0;
    step_d            = step_cur;
    cmd_done          = 1'b0;
    unique case (step_cur)
      ST_CTRL: begin
        res_new.tx_byte = cmd_i.ctrl;
        step_d          = ST_SRC_H;
      end
      ST_SRC_H: begin
        res_new.tx_byte = cfg_i.own_addr_high;
        step_d          = ST_SRC_L;
      end
      ST_SRC_L: begin
        res_new.tx_byte = cfg_i.own_addr_low;
        step_d          = ST_DST_H;
      end
      ST_DST_H: begin
        res_new.tx_byte = cfg_i.dest_high;
        step_d          = ST_DST_L;
      end
      ST_DST_L: begin
        res_new.tx_byte = cmd_i.dest_low;
        step_d          = ST_LEN;
      end
      ST_LEN: begin
        res_new.tx_byte = {4'b0000, cmd_i.length};
        step_d          = ST_DATA;
      end
      ST_DATA: begin
        res_new.tx_byte  = cmd_i.data;
        res_new.run_last = !cmd_i.last;
        cmd_done         = !cmd_i.last;
        step_d           = ST_CHK;
      end
      ST_CHK: begin
        res_new.tx_byte   = ~accum_q;
        res_new.run_last  = 1'b1;
        res_new.frame_end = 1'b1;
        cmd_done          = 1'b1;
      end
      default: begin
        res_new.tx_byte = cmd_i.data;
        cmd_done        = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o = emit && cmd_done;

  always_comb begin
    mid_d   = mid_q;
    accum_d = accum_q;
    if (emit) begin
      mid_d = !cmd_done;
      if (step_cur == ST_CTRL) begin
        accum_d = res_new.tx_byte;
      end else if (step_cur == ST_CHK) begin
        accum_d = '0;
      end else begin
        accum_d = accum_q ^ res_new.tx_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= ST_CTRL;
      mid_q    <= 1'b0;
      accum_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (emit) begin
        step_q   <= step_d;
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      mid_q   <= mid_d;
      accum_q <= accum_d;
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({emit, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

[rtl/bus_telegram_framer_top.sv]
// ----------------------------------------------------------------------------
// bus_telegram_framer_top
// Frames payload bytes into standard twisted-pair bus telegrams.
// ----------------------------------------------------------------------------
// usage
//   input queue: drive the payload fields and raise push while full is low
//   result queue: while empty is low the oldest byte is on tx_byte_o,
//   run_last_o and frame_end_o; pop takes it
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i, ready is always high; write only while the block is idle
// timing
//   a request reaches the byte sequencer one cycle after push, its first
//   byte shows two cycles after push
//   the sequencer sends one byte per cycle: a frame opening request takes
//   7 or 8 cycles, a later payload byte 1, the closing one 2
//   throughput is set by the single byte sequencer
// reset
//   no frame open, both queues empty, address registers at defaults
// stalls
//   a held result queue stops the sequencer, then the two-entry request
//   queue fills and full rises
// ----------------------------------------------------------------------------
module bus_telegram_framer_top import btf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic [1:0]           priority_req_i,
  input  logic                 repeat_flag_i,
  input  logic [7:0]           dest_low_i,
  input  logic [3:0]           length_code_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           tx_byte_o,
  output logic                 run_last_o,
  output logic                 frame_end_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr_high <= OWN_ADDR_HIGH_RST;
      cfg_q.own_addr_low  <= OWN_ADDR_LOW_RST;
      cfg_q.dest_high     <= DEST_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_OWN_ADDR_HIGH: cfg_q.own_addr_high <= cfg_data_i;
        REG_OWN_ADDR_LOW:  cfg_q.own_addr_low  <= cfg_data_i;
        REG_DEST_HIGH:     cfg_q.dest_high     <= cfg_data_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  btf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .priority_req_i (priority_req_i),
    .repeat_flag_i  (repeat_flag_i),
    .dest_low_i     (dest_low_i),
    .length_code_i  (length_code_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  btf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign tx_byte_o   = res.tx_byte;
  assign run_last_o  = res.run_last;
  assign frame_end_o = res.frame_end;

endmodule

[sim/bus_telegram_framer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_telegram_framer_top_tb
// Self-checking bench for the telegram framer. Payload requests are pushed
// through a directed table and then through randomized frames under three
// idle mixes, with address register changes between phases. A behavioral
// predictor builds every header, payload and checksum byte. Each popped byte
// is compared against the oldest predicted entry.
// ----------------------------------------------------------------------------
module bus_telegram_framer_top_tb;
  import btf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] prio;
    logic       rep;
    logic [7:0] dlow;
    logic [3:0] len;
    logic       typed;
    logic [7:0] exp_head;
    logic [7:0] exp_tail;
  } stim_t;

  // typed rows hold the control byte and the closing checksum at reset defaults
  localparam int DIR_ROWS = 12;
  localparam stim_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b1, 2'd0, 1'b0, 8'h00, 4'h0, 1'b1, 8'hB0, 8'h4D},
    '{8'hFF, 1'b1, 2'd3, 1'b1, 8'hFF, 4'hF, 1'b1, 8'h9C, 8'h6E},
    '{8'h5A, 1'b0, 2'd2, 1'b0, 8'h34, 4'h3, 1'b0, 8'h00, 8'h00},
    '{8'hA5, 1'b0, 2'd1, 1'b1, 8'h99, 4'h9, 1'b0, 8'h00, 8'h00},
    '{8'h3C, 1'b1, 2'd3, 1'b1, 8'h77, 4'h2, 1'b0, 8'h00, 8'h00},
    '{8'h80, 1'b0, 2'd1, 1'b0, 8'h12, 4'hF, 1'b0, 8'h00, 8'h00},
    '{8'h01, 1'b1, 2'd0, 1'b1, 8'h00, 4'h0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b1, 2'd2, 1'b1, 8'hAA, 4'h5, 1'b1, 8'h98, 8'hCA},
    '{8'h55, 1'b0, 2'd3, 1'b0, 8'hF0, 4'h1, 1'b0, 8'h00, 8'h00},
    '{8'hAA, 1'b0, 2'd0, 1'b0, 8'h0F, 4'hE, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 2'd0, 1'b0, 8'h00, 4'h0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 2'd1, 1'b1, 8'h5A, 4'h7, 1'b0, 8'h00, 8'h00}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [7:0]           data_byte_i;
  logic                 last_byte_i;
  logic [1:0]           priority_req_i;
  logic                 repeat_flag_i;
  logic [7:0]           dest_low_i;
  logic [3:0]           length_code_i;
  logic                 empty;
  logic                 pop;
  logic [7:0]           tx_byte_o;
  logic                 run_last_o;
  logic                 frame_end_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  cfg_t       reg_model;
  logic       frame_open_m;
  logic [7:0] check_acc;
  res_t       tx_expect_q [$];
  res_t       want;
  int         mismatches;
  int         cycle_cnt;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_req;

  bus_telegram_framer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .priority_req_i (priority_req_i),
    .repeat_flag_i  (repeat_flag_i),
    .dest_low_i     (dest_low_i),
    .length_code_i  (length_code_i),
    .empty          (empty),
    .pop            (pop),
    .tx_byte_o      (tx_byte_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void queue_tx_byte(input logic [7:0] b, input logic is_chk);
    res_t r;
    r.tx_byte   = b;
    r.run_last  = 1'b0;
    r.frame_end = is_chk;
    tx_expect_q.push_back(r);
    check_acc = check_acc ^ b;
  endfunction

  task automatic predict_telegram(input stim_t it);
    logic [7:0] ctrl;
    int         head_idx;
    head_idx = tx_expect_q.size();
    if (!frame_open_m) begin
      ctrl = CTRL_BASE;
      if (it.rep) begin
        ctrl = ctrl & CTRL_REPEAT_MASK;
      end else begin
        ctrl = ctrl | CTRL_NOREPEAT;
      end
      ctrl = ctrl | {4'b0, it.prio, 2'b0};
      check_acc = 8'h00;
      queue_tx_byte(ctrl, 1'b0);
      queue_tx_byte(reg_model.own_addr_high, 1'b0);
      queue_tx_byte(reg_model.own_addr_low, 1'b0);
      queue_tx_byte(reg_model.dest_high, 1'b0);
      queue_tx_byte(it.dlow, 1'b0);
      queue_tx_byte({4'b0, it.len}, 1'b0);
      frame_open_m = 1'b1;
    end
    queue_tx_byte(it.data, 1'b0);
    if (it.last) begin
      queue_tx_byte(~check_acc, 1'b1);
      frame_open_m = 1'b0;
      check_acc = 8'h00;
    end
    tx_expect_q[tx_expect_q.size()-1].run_last = 1'b1;
    if (it.typed) begin
      tx_expect_q[head_idx].tx_byte = it.exp_head;
      tx_expect_q[tx_expect_q.size()-1].tx_byte = it.exp_tail;
    end
  endtask

  // enter and leave at a falling edge
  task automatic push_item(input stim_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push           = 1'b1;
    data_byte_i    = it.data;
    last_byte_i    = it.last;
    priority_req_i = it.prio;
    repeat_flag_i  = it.rep;
    dest_low_i     = it.dlow;
    length_code_i  = it.len;
    do @(posedge clk_i); while (full);
    predict_telegram(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push = 1'b0;
    while (tx_expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OWN_ADDR_HIGH: reg_model.own_addr_high = val;
      REG_OWN_ADDR_LOW:  reg_model.own_addr_low  = val;
      REG_DEST_HIGH:     reg_model.dest_high     = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] ah, input logic [7:0] al,
                              input logic [7:0] dh);
    write_reg(REG_OWN_ADDR_HIGH, ah);
    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
    write_reg(REG_OWN_ADDR_LOW, al);
    write_reg(REG_DEST_HIGH, dh);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input bit hold);
    stim_t r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold) begin
      hold_req++;
    end
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        drain();
      end
      r.data     = 8'($urandom_range(0, 255));
      r.last     = ($urandom_range(0, 3) == 0);
      r.prio     = 2'($urandom_range(0, 3));
      r.rep      = 1'($urandom_range(0, 1));
      r.dlow     = 8'($urandom_range(0, 255));
      r.len      = 4'($urandom_range(0, 15));
      r.typed    = 1'b0;
      r.exp_head = 8'h00;
      r.exp_tail = 8'h00;
      push_item(r);
    end
    drain();
  endtask

  // receiver: random pops, plus a long hold-off on request
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack  = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (tx_expect_q.size() == 0) begin
        $error("unexpected byte: tx_byte %h", tx_byte_o);
        mismatches++;
      end else begin
        want = tx_expect_q.pop_front();
        if (tx_byte_o !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, tx_byte_o);
          mismatches++;
        end
        if (run_last_o !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, run_last_o);
          mismatches++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, frame_end_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches     = 0;
    cycle_cnt      = 0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    hold_req       = 0;
    reg_model      = '{OWN_ADDR_HIGH_RST, OWN_ADDR_LOW_RST, DEST_HIGH_RST};
    frame_open_m   = 1'b0;
    check_acc      = 8'h00;
    rst_ni         = 1'b0;
    push           = 1'b0;
    data_byte_i    = 8'h00;
    last_byte_i    = 1'b0;
    priority_req_i = 2'd0;
    repeat_flag_i  = 1'b0;
    dest_low_i     = 8'h00;
    length_code_i  = 4'h0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_OWN_ADDR_HIGH;
    cfg_data_i     = 8'h00;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      push_item(DIR_TAB[i]);
    end
    drain();

    // the directed table leaves a frame open across this write
    program_regs(8'h00, 8'h00, 8'h00);
    run_phase(100, 17, 83, 1'b0);
    program_regs(8'hFF, 8'hFF, 8'hFF);
    run_phase(100, 83, 17, 1'b0);
    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    run_phase(110, 0, 0, 1'b1);

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
